// ----- hw/rtl/csll_pkg.sv -----
// ----------------------------------------------------------------------------
// csll_pkg
// Shared constants, codes and types of the sorted record list with free list.
// ----------------------------------------------------------------------------
package csll_pkg;

  // Default sizing, handed to the top level parameters.
  localparam int SLOTS_DEF      = 16;
  localparam int NAME_BYTES_DEF = 8;

  // A walk emits at most this many entries.
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  // Field widths of the item and result channels.
  localparam int FUNC_W   = 2;
  localparam int NAME_W   = 64;
  localparam int INIT_W   = 8;
  localparam int YEARS_W  = 7;
  localparam int CAT_W    = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WALK   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  // One stored record.
  typedef struct packed {
    logic [NAME_W-1:0]  key;
    logic [NAME_W-1:0]  given;
    logic [INIT_W-1:0]  mid_init;
    logic [YEARS_W-1:0] years;
    logic [CAT_W-1:0]   category;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                latch_item;
    logic                take_slot;
    logic                pop_free;
    logic                push_link;
    logic                scan_start;
    logic                scan_step;
    logic                link_new;
    logic                link_prev;
    logic                free_return;
    logic                walk_start;
    logic                walk_emit;
    logic                resp_load;
    logic [STATUS_W-1:0] resp_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              free_empty;
    logic              list_empty;
    logic              link_nil;
    logic              key_gt;
    logic              key_eq;
    logic              prev_nil;
    logic              walk_last;
    logic              out_free;
  } sts_t;

  // Keeps the high name bytes and clears the rest.
  function automatic logic [NAME_W-1:0] name_mask(input int nb);
    logic [NAME_W-1:0] m;
    m = {NAME_W{1'b1}};
    return m << (8 * (8 - nb));
  endfunction

endpackage

// ----- hw/rtl/csll_in_if.sv -----
// ----------------------------------------------------------------------------
// csll_in_if
// Item channel of the record list: valid/ready handshake and request fields.
// ----------------------------------------------------------------------------
interface csll_in_if;
  logic                            valid;
  logic                            ready;
  logic [csll_pkg::FUNC_W-1:0]     func;
  logic [csll_pkg::NAME_W-1:0]     key_name;
  logic [csll_pkg::NAME_W-1:0]     given_name;
  logic [csll_pkg::INIT_W-1:0]     initial_req;
  logic [csll_pkg::YEARS_W-1:0]    years;
  logic [csll_pkg::CAT_W-1:0]      category;

  modport source (
    output valid, func, key_name, given_name, initial_req, years, category,
    input  ready
  );
  modport sink (
    input  valid, func, key_name, given_name, initial_req, years, category,
    output ready
  );
endinterface

// ----- hw/rtl/csll_out_if.sv -----
// ----------------------------------------------------------------------------
// csll_out_if
// Result channel of the record list: valid/ready handshake and result fields.
// ----------------------------------------------------------------------------
interface csll_out_if;
  logic                            valid;
  logic                            ready;
  logic [csll_pkg::STATUS_W-1:0]   status;
  logic [csll_pkg::SLOT_W-1:0]     slot;
  logic [csll_pkg::NAME_W-1:0]     out_key;
  logic [csll_pkg::NAME_W-1:0]     out_given;
  logic [csll_pkg::INIT_W-1:0]     out_initial;
  logic [csll_pkg::YEARS_W-1:0]    out_years;
  logic [csll_pkg::CAT_W-1:0]      out_category;
  logic                            last;

  modport source (
    output valid, status, slot, out_key, out_given, out_initial, out_years,
           out_category, last,
    input  ready
  );
  modport sink (
    input  valid, status, slot, out_key, out_given, out_initial, out_years,
           out_category, last,
    output ready
  );
endinterface

// ----- hw/rtl/csll_ram.sv -----
// ----------------------------------------------------------------------------
// csll_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module csll_ram #(
  parameter  int WIDTH = csll_pkg::REC_W,
  parameter  int DEPTH = csll_pkg::SLOTS_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/csll_ctrl.sv -----
// ----------------------------------------------------------------------------
// csll_ctrl
// Sequencer of the record list: decodes an item and steps the datapath
// through allocation, list scan, relinking and result delivery.
// ----------------------------------------------------------------------------
module csll_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  csll_pkg::sts_t    sts,
  output csll_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DISP  = 8'b0000_0010,
    S_ALLOC = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_LINK  = 8'b0001_0000,
    S_LINK2 = 8'b0010_0000,
    S_RESP  = 8'b0100_0000,
    S_WALK  = 8'b1000_0000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [csll_pkg::STATUS_W-1:0] code_r, code_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt    = state_r;
    code_nxt     = code_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.resp_code = code_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          state_nxt      = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.func) inside
          csll_pkg::FUNC_PUSH, csll_pkg::FUNC_INSERT: begin
            if (sts.free_empty) begin
              code_nxt  = csll_pkg::ST_FULL;
              state_nxt = S_RESP;
            end else begin
              cmd.take_slot = 1'b1;
              state_nxt     = S_ALLOC;
            end
          end
          csll_pkg::FUNC_WALK: begin
            if (sts.list_empty) begin
              code_nxt  = csll_pkg::ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              cmd.walk_start = 1'b1;
              state_nxt      = S_WALK;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_ALLOC: begin
        // The free head moves on to the link of the slot just taken.
        cmd.pop_free = 1'b1;
        if (sts.func == csll_pkg::FUNC_PUSH) begin
          cmd.push_link = 1'b1;
          code_nxt      = csll_pkg::ST_INSERTED;
          state_nxt     = S_RESP;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = sts.list_empty ? S_LINK : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.key_gt) begin
          cmd.scan_step = 1'b1;
          if (sts.link_nil) begin
            state_nxt = S_LINK;
          end
        end else if (sts.key_eq) begin
          cmd.free_return = 1'b1;
          code_nxt        = csll_pkg::ST_DUP;
          state_nxt       = S_RESP;
        end else begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        cmd.link_new = 1'b1;
        code_nxt     = csll_pkg::ST_INSERTED;
        state_nxt    = sts.prev_nil ? S_RESP : S_LINK2;
      end
      S_LINK2: begin
        cmd.link_prev = 1'b1;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_WALK: begin
        if (sts.out_free) begin
          cmd.walk_emit = 1'b1;
          if (sts.walk_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= csll_pkg::ST_INSERTED;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

// ----- hw/rtl/csll_dp.sv -----
// ----------------------------------------------------------------------------
// csll_dp
// Datapath of the record list: record and link memories, list and free
// heads, scan pointers, key compare and the result register.
// ----------------------------------------------------------------------------
module csll_dp #(
  parameter int SLOTS      = csll_pkg::SLOTS_DEF,
  parameter int NAME_BYTES = csll_pkg::NAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  csll_pkg::cmd_t                 cmd,
  output csll_pkg::sts_t                 sts,
  input  logic [csll_pkg::FUNC_W-1:0]    func,
  input  logic [csll_pkg::NAME_W-1:0]    key_name,
  input  logic [csll_pkg::NAME_W-1:0]    given_name,
  input  logic [csll_pkg::INIT_W-1:0]    initial_req,
  input  logic [csll_pkg::YEARS_W-1:0]   years,
  input  logic [csll_pkg::CAT_W-1:0]     category,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [csll_pkg::STATUS_W-1:0]  out_status,
  output logic [csll_pkg::SLOT_W-1:0]    out_slot,
  output csll_pkg::rec_t                 out_rec,
  output logic                           out_last
);

  localparam int IW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam logic [PW-1:0] NIL = PW'(SLOTS);
  localparam logic [csll_pkg::NAME_W-1:0] MASK = csll_pkg::name_mask(NAME_BYTES);
  localparam logic [csll_pkg::CNT_W-1:0] CNT_LAST = csll_pkg::CNT_W'(csll_pkg::MAX_RESULTS - 1);

  logic [csll_pkg::FUNC_W-1:0]   func_r;
  csll_pkg::rec_t                item_r;
  logic [PW-1:0]                 free_head_r, list_head_r, s_r, cur_r, prev_r;
  logic [csll_pkg::CNT_W-1:0]    n_r;
  logic [SLOTS-1:0]              lvalid_r;
  logic                          lv_q;
  logic [PW-1:0]                 dflt_q;
  logic [PW-1:0]                 link_rd, link_q;
  csll_pkg::rec_t                rec_q;
  logic [PW-1:0]                 rd_addr;
  logic [IW-1:0]                 ra;
  logic                          lw_en;
  logic [IW-1:0]                 lw_addr;
  logic [PW-1:0]                 lw_data;
  logic                          load;
  logic                          out_valid_r;
  logic [csll_pkg::STATUS_W-1:0] out_status_r;
  logic [csll_pkg::SLOT_W-1:0]   out_slot_r;
  csll_pkg::rec_t                out_rec_r;
  logic                          out_last_r;

  // Read address: follows the pointer the current step moves to.
  always_comb begin
    if (cmd.take_slot) begin
      rd_addr = free_head_r;
    end else if (cmd.scan_start || cmd.walk_start) begin
      rd_addr = list_head_r;
    end else if (cmd.scan_step || cmd.walk_emit) begin
      rd_addr = link_q;
    end else begin
      rd_addr = cur_r;
    end
  end
  assign ra = rd_addr[IW-1:0];

  // Link write port: new slot's link, or the predecessor's link.
  assign lw_en   = cmd.push_link || cmd.link_new || cmd.link_prev;
  assign lw_addr = cmd.link_prev ? prev_r[IW-1:0] : s_r[IW-1:0];
  assign lw_data = cmd.push_link ? list_head_r : (cmd.link_new ? cur_r : s_r);

  csll_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (lw_en),
    .waddr (lw_addr),
    .wdata (lw_data),
    .raddr (ra),
    .rdata (link_rd)
  );

  csll_ram #(.WIDTH(csll_pkg::REC_W), .DEPTH(SLOTS)) u_rec_ram (
    .clk   (clk),
    .we    (cmd.take_slot),
    .waddr (free_head_r[IW-1:0]),
    .wdata (item_r),
    .raddr (ra),
    .rdata (rec_q)
  );

  // A link never written reads as its reset value: the slot below, or null.
  assign link_q = lv_q ? link_rd : dflt_q;

  always_ff @(posedge clk) begin
    lv_q   <= lvalid_r[ra];
    dflt_q <= (ra == '0) ? NIL : (PW'(ra) - PW'(1));
  end

  // List and free list heads, and the marks of links written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvalid_r    <= '0;
      free_head_r <= PW'(SLOTS - 1);
      list_head_r <= NIL;
    end else begin
      if (lw_en) begin
        lvalid_r[lw_addr] <= 1'b1;
      end
      if (cmd.pop_free) begin
        free_head_r <= link_q;
      end else if (cmd.free_return) begin
        free_head_r <= s_r;
      end
      if (cmd.push_link || (cmd.link_new && prev_r == NIL)) begin
        list_head_r <= s_r;
      end
    end
  end

  // Item capture (name bytes beyond the kept width cleared), slot and pointers.
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      func_r         <= func;
      item_r.key     <= key_name & MASK;
      item_r.given   <= given_name & MASK;
      item_r.mid_init <= initial_req;
      item_r.years   <= years;
      item_r.category <= category;
    end
    if (cmd.take_slot) begin
      s_r <= free_head_r;
    end
    if (cmd.scan_start) begin
      cur_r  <= list_head_r;
      prev_r <= NIL;
    end else if (cmd.scan_step) begin
      cur_r  <= link_q;
      prev_r <= cur_r;
    end else if (cmd.walk_start) begin
      cur_r <= list_head_r;
    end else if (cmd.walk_emit) begin
      cur_r <= link_q;
    end
    if (cmd.walk_start) begin
      n_r <= '0;
    end else if (cmd.walk_emit) begin
      n_r <= n_r + 1'b1;
    end
  end

  // Result register.
  assign load = cmd.resp_load || cmd.walk_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_emit) begin
      out_status_r <= csll_pkg::ST_ENTRY;
      out_slot_r   <= csll_pkg::SLOT_W'(cur_r);
      out_rec_r    <= rec_q;
      out_last_r   <= sts.walk_last;
    end else if (cmd.resp_load) begin
      out_status_r <= cmd.resp_code;
      out_last_r   <= 1'b1;
      if (cmd.resp_code == csll_pkg::ST_INSERTED) begin
        out_slot_r <= csll_pkg::SLOT_W'(s_r);
        out_rec_r  <= item_r;
      end else if (cmd.resp_code == csll_pkg::ST_DUP) begin
        out_slot_r <= csll_pkg::SLOT_W'(cur_r);
        out_rec_r  <= '0;
      end else begin
        out_slot_r <= '0;
        out_rec_r  <= '0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_rec    = out_rec_r;
  assign out_last   = out_last_r;

  // Status toward the controller.
  always_comb begin
    sts.func       = func_r;
    sts.free_empty = (free_head_r == NIL);
    sts.list_empty = (list_head_r == NIL);
    sts.link_nil   = (link_q == NIL);
    sts.key_gt     = (rec_q.key > item_r.key);
    sts.key_eq     = (rec_q.key == item_r.key);
    sts.prev_nil   = (prev_r == NIL);
    sts.walk_last  = (link_q == NIL) || (n_r == CNT_LAST);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // A slot is only taken from a nonempty free list.
  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_slot |-> free_head_r != NIL)
    else $error("slot taken from an empty free list");

  // The result register is only loaded once it has been emptied.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  // Walk entries and scan steps always sit on a listed slot.
  a_cur_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk_emit || cmd.scan_step) |-> cur_r != NIL)
    else $error("list pointer is null where an entry is expected");

  // After a slot is allocated the new free head is a slot or null.
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_free |=> free_head_r <= NIL)
    else $error("free head out of range");

endmodule

// ----- hw/rtl/cursor_sorted_list_with_free_list.sv -----
// ----------------------------------------------------------------------------
// cursor_sorted_list_with_free_list
// Record pool with a free list and one linked list: push at head, insert in
// descending key order with duplicate rejection, and a walk over the list.
// ----------------------------------------------------------------------------
// Push: the item is accepted, dispatched, given a slot and answered; the next
// item is taken once the result is loaded. Insert: one compare per entry (up
// to SLOTS - 1, one link-memory read each), then the link step, plus one more
// when the record goes behind another entry. Walk: one result per cycle while
// results are taken, set by the link memory's read port. Reset clears the
// list and chains every slot into the free list from the top slot down.
// ----------------------------------------------------------------------------
module cursor_sorted_list_with_free_list #(
  parameter int SLOTS      = csll_pkg::SLOTS_DEF,
  parameter int NAME_BYTES = csll_pkg::NAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  csll_in_if.sink    in_ch,
  csll_out_if.source out_ch
);

  csll_pkg::cmd_t cmd;
  csll_pkg::sts_t sts;
  csll_pkg::rec_t out_rec;
  logic           in_ready;

  csll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csll_dp #(.SLOTS(SLOTS), .NAME_BYTES(NAME_BYTES)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .func        (in_ch.func),
    .key_name    (in_ch.key_name),
    .given_name  (in_ch.given_name),
    .initial_req (in_ch.initial_req),
    .years       (in_ch.years),
    .category    (in_ch.category),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_status  (out_ch.status),
    .out_slot    (out_ch.slot),
    .out_rec     (out_rec),
    .out_last    (out_ch.last)
  );

  // Channel wiring.
  assign in_ch.ready         = in_ready;
  assign out_ch.out_key      = out_rec.key;
  assign out_ch.out_given    = out_rec.given;
  assign out_ch.out_initial  = out_rec.mid_init;
  assign out_ch.out_years    = out_rec.years;
  assign out_ch.out_category = out_rec.category;

endmodule

// ----- verif/tb_cursor_sorted_list_with_free_list.sv -----
// ----------------------------------------------------------------------------
// tb_cursor_sorted_list_with_free_list
// Self-checking bench for the record pool with free list and sorted list.
// A directed table covers the empty list, the field extremes, duplicate keys
// and unknown operations. Random pushes, inserts and walks follow, then the
// pool is filled and the pool-full answers are checked. Every result item is
// compared with a hand-written answer or the output of a behavioral copy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cursor_sorted_list_with_free_list;
  import csll_pkg::*;

  localparam int POOL_SLOTS  = SLOTS_DEF;
  localparam int RAND_ITEMS  = 480;
  localparam int HOLD_CYCLES = 600;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 40;

  // Operation code that the block ignores.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [NAME_W-1:0] KEEP_MASK =
    {NAME_W{1'b1}} << (8 * (8 - NAME_BYTES_DEF));

  // Slot links carry one extra bit so that the null link lies past the pool.
  typedef logic [SLOT_W:0] link_t;
  localparam link_t NIL_SLOT = link_t'(POOL_SLOTS);

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [NAME_W-1:0]  key;
    logic [NAME_W-1:0]  given;
    logic [INIT_W-1:0]  mid_init;
    logic [YEARS_W-1:0] years;
    logic [CAT_W-1:0]   category;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [NAME_W-1:0]   key;
    logic [NAME_W-1:0]   given;
    logic [INIT_W-1:0]   mid_init;
    logic [YEARS_W-1:0]  years;
    logic [CAT_W-1:0]    category;
    logic                last;
  } resp_t;

  // One item to send, with a hand-written answer where fixed is set.
  typedef struct packed {
    req_t                req;
    logic                fixed;
    logic [STATUS_W-1:0] fixed_status;
    logic [SLOT_W-1:0]   fixed_slot;
  } plan_t;

  logic clk;
  logic rst_n;

  csll_in_if  in_if ();
  csll_out_if out_if ();

  cursor_sorted_list_with_free_list u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Shadow copy of the pool and of both chains.
  link_t       slot_link [POOL_SLOTS];
  rec_t        slot_rec  [POOL_SLOTS];
  link_t       free_top;
  link_t       list_top;
  resp_t       due_results [$];
  int unsigned fail_cnt;
  int unsigned taken_cnt;
  int unsigned idle_cyc;
  bit          steady;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic resp_t status_resp(input logic [STATUS_W-1:0] st,
                                        input link_t s);
    resp_t x;
    x = '0;
    x.status = st;
    x.slot   = s[SLOT_W-1:0];
    x.last   = 1'b1;
    return x;
  endfunction

  function automatic resp_t record_resp(input logic [STATUS_W-1:0] st,
                                        input link_t s, input logic fin);
    resp_t x;
    x.status   = st;
    x.slot     = s[SLOT_W-1:0];
    x.key      = slot_rec[s].key;
    x.given    = slot_rec[s].given;
    x.mid_init = slot_rec[s].mid_init;
    x.years    = slot_rec[s].years;
    x.category = slot_rec[s].category;
    x.last     = fin;
    return x;
  endfunction

  // Applies one accepted item to the shadow list and returns its results.
  function automatic void apply_list_op(input req_t r, ref resp_t outs[$]);
    link_t s;
    link_t prev;
    link_t cur;
    link_t nx;
    int    steps;
    rec_t  nr;
    nr.key      = r.key & KEEP_MASK;
    nr.given    = r.given & KEEP_MASK;
    nr.mid_init = r.mid_init;
    nr.years    = r.years;
    nr.category = r.category;
    outs.delete();
    case (r.func)
      FUNC_PUSH: begin
        if (free_top == NIL_SLOT) begin
          outs.push_back(status_resp(ST_FULL, '0));
        end else begin
          s = free_top;
          free_top = slot_link[s];
          slot_rec[s] = nr;
          slot_link[s] = list_top;
          list_top = s;
          outs.push_back(record_resp(ST_INSERTED, s, 1'b1));
        end
      end
      FUNC_INSERT: begin
        if (free_top == NIL_SLOT) begin
          outs.push_back(status_resp(ST_FULL, '0));
        end else begin
          s = free_top;
          free_top = slot_link[s];
          slot_rec[s] = nr;
          prev = NIL_SLOT;
          cur = list_top;
          steps = 0;
          // Scan past every larger key; the list may be unsorted after pushes.
          while (cur != NIL_SLOT && steps < POOL_SLOTS && slot_rec[cur].key > nr.key) begin
            prev = cur;
            cur = slot_link[cur];
            steps++;
          end
          if (cur != NIL_SLOT && slot_rec[cur].key == nr.key) begin
            // A rejected key hands its slot back to the free list head.
            slot_link[s] = free_top;
            free_top = s;
            outs.push_back(status_resp(ST_DUP, cur));
          end else begin
            slot_link[s] = cur;
            if (prev != NIL_SLOT) slot_link[prev] = s;
            else list_top = s;
            outs.push_back(record_resp(ST_INSERTED, s, 1'b1));
          end
        end
      end
      FUNC_WALK: begin
        if (list_top == NIL_SLOT) begin
          outs.push_back(status_resp(ST_EMPTY, '0));
        end else begin
          cur = list_top;
          steps = 0;
          while (cur != NIL_SLOT && steps < MAX_RESULTS) begin
            nx = slot_link[cur];
            outs.push_back(record_resp(ST_ENTRY, cur,
                                       nx == NIL_SLOT || steps == MAX_RESULTS - 1));
            steps++;
            cur = nx;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic req_t req_of(input logic [FUNC_W-1:0] f,
                                  input logic [NAME_W-1:0] k,
                                  input logic [NAME_W-1:0] g,
                                  input logic [INIT_W-1:0] ini,
                                  input logic [YEARS_W-1:0] yrs,
                                  input logic [CAT_W-1:0] cat);
    req_t r;
    r.func     = f;
    r.key      = k;
    r.given    = g;
    r.mid_init = ini;
    r.years    = yrs;
    r.category = cat;
    return r;
  endfunction

  function automatic req_t rand_req(input logic [FUNC_W-1:0] f);
    return req_of(f, {$urandom, $urandom}, {$urandom, $urandom}, INIT_W'($urandom),
                  YEARS_W'($urandom), CAT_W'($urandom));
  endfunction

  function automatic plan_t mk_row(input req_t r, input logic fx,
                                   input logic [STATUS_W-1:0] st,
                                   input logic [SLOT_W-1:0] sl);
    plan_t p;
    p.req          = r;
    p.fixed        = fx;
    p.fixed_status = st;
    p.fixed_slot   = sl;
    return p;
  endfunction

  // Key of a random listed record, so that inserts often hit a duplicate.
  function automatic logic [NAME_W-1:0] listed_key();
    link_t       cur;
    int unsigned hops;
    if (list_top == NIL_SLOT) return {$urandom, $urandom};
    cur = list_top;
    hops = $urandom_range(0, POOL_SLOTS - 1);
    while (hops > 0 && slot_link[cur] != NIL_SLOT) begin
      cur = slot_link[cur];
      hops--;
    end
    return slot_rec[cur].key;
  endfunction

  // Mostly short gaps, now and then a long one, none in a steady stretch.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic string resp_text(input resp_t x);
    return $sformatf("st=%0d slot=%0d key=%h given=%h ini=%h yrs=%0d cat=%0d last=%0b",
                     x.status, x.slot, x.key, x.given, x.mid_init, x.years,
                     x.category, x.last);
  endfunction

  // Sends one item after a gap and books its results once it is accepted.
  task automatic run_row(input plan_t p);
    resp_t       got_q [$];
    resp_t       want;
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.func        <= p.req.func;
    in_if.key_name    <= p.req.key;
    in_if.given_name  <= p.req.given;
    in_if.initial_req <= p.req.mid_init;
    in_if.years       <= p.req.years;
    in_if.category    <= p.req.category;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    apply_list_op(p.req, got_q);
    if (p.fixed) begin
      want = '0;
      want.status = p.fixed_status;
      want.slot   = p.fixed_slot;
      want.last   = 1'b1;
      if (p.fixed_status == ST_INSERTED) begin
        want.key      = p.req.key;
        want.given    = p.req.given;
        want.mid_init = p.req.mid_init;
        want.years    = p.req.years;
        want.category = p.req.category;
      end
      due_results.push_back(want);
    end else begin
      foreach (got_q[i]) due_results.push_back(got_q[i]);
    end
  endtask

  // Stimulus: directed table, random items, then the pool-full checks.
  initial begin : stimulus
    plan_t       plan [$];
    req_t        r;
    int unsigned k;
    int unsigned pick;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.func        <= FUNC_PUSH;
    in_if.key_name    <= '0;
    in_if.given_name  <= '0;
    in_if.initial_req <= '0;
    in_if.years       <= '0;
    in_if.category    <= '0;
    steady    = 1'b0;
    fail_cnt  = 0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      slot_link[i] = (i == 0) ? NIL_SLOT : link_t'(i - 1);
      slot_rec[i]  = '0;
    end
    free_top = link_t'(POOL_SLOTS - 1);
    list_top = NIL_SLOT;

    // Walk of the empty list, an ignored code, then the field extremes.
    plan.push_back(mk_row(req_of(FUNC_WALK, '0, '0, '0, '0, '0), 1'b1, ST_EMPTY, 4'd0));
    plan.push_back(mk_row(rand_req(FUNC_UNUSED), 1'b0, ST_INSERTED, 4'd0));
    plan.push_back(mk_row(req_of(FUNC_PUSH, '0, '0, '0, '0, '0), 1'b1, ST_INSERTED, 4'd15));
    plan.push_back(mk_row(req_of(FUNC_INSERT, '1, '1, '1, '1, 2'd3),
                          1'b1, ST_INSERTED, 4'd14));
    plan.push_back(mk_row(req_of(FUNC_INSERT, '0, 64'h1234, 8'h5a, 7'd9, 2'd1),
                          1'b1, ST_DUP, 4'd15));
    plan.push_back(mk_row(rand_req(FUNC_WALK), 1'b0, ST_INSERTED, 4'd0));
    // The slot handed back by the duplicate is the next one taken.
    plan.push_back(mk_row(req_of(FUNC_PUSH, 64'h8000_0000_0000_0000,
                                 64'h414e_4e00_0000_0000, 8'h4c, 7'd42, 2'd2),
                          1'b1, ST_INSERTED, 4'd13));
    plan.push_back(mk_row(req_of(FUNC_INSERT, 64'h8000_0000_0000_0001,
                                 64'h4245_4e00_0000_0000, 8'h00, 7'd1, 2'd1),
                          1'b0, ST_INSERTED, 4'd0));
    plan.push_back(mk_row(req_of(FUNC_INSERT, 64'h7fff_ffff_ffff_ffff,
                                 64'h0000_0000_0000_0001, 8'h80, 7'd64, 2'd0),
                          1'b0, ST_INSERTED, 4'd0));
    plan.push_back(mk_row(req_of(FUNC_INSERT, 64'h0000_0000_0000_0001,
                                 64'hffff_ffff_ffff_fffe, 8'h7f, 7'd63, 2'd2),
                          1'b0, ST_INSERTED, 4'd0));
    // The push left the list unsorted, so this equal key slips in.
    plan.push_back(mk_row(req_of(FUNC_INSERT, '1, 64'h5a5a_5a5a_a5a5_a5a5, 8'h01,
                                 7'd2, 2'd3), 1'b0, ST_INSERTED, 4'd0));
    plan.push_back(mk_row(req_of(FUNC_INSERT, 64'h8000_0000_0000_0001,
                                 64'ha5a5_a5a5_5a5a_5a5a, 8'hfe, 7'd126, 2'd0),
                          1'b0, ST_INSERTED, 4'd0));
    plan.push_back(mk_row(rand_req(FUNC_WALK), 1'b0, ST_INSERTED, 4'd0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) run_row(plan[i]);

    // Random part: inserts lean on listed keys and their neighbors.
    k = 0;
    while (k < RAND_ITEMS) begin
      steady = (k >= 100 && k < 160);
      if (k == 300) begin
        // Withdraw the item just taken so that it is not offered again.
        in_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        r = rand_req(FUNC_INSERT);
        pick = $urandom_range(0, 99);
        if (pick < 60) r.key = listed_key();
        else if (pick < 75) r.key = listed_key() + ($urandom_range(0, 1) ? 64'd1 : '1);
      end else if (pick < 60) begin
        r = rand_req(FUNC_PUSH);
      end else if (pick < 96) begin
        r = rand_req(FUNC_WALK);
      end else begin
        r = rand_req(FUNC_UNUSED);
      end
      run_row(mk_row(r, 1'b0, ST_INSERTED, 4'd0));
      if (r.func != FUNC_UNUSED) k++;
    end
    steady = 1'b0;

    // Fill what is left of the pool, then check the pool-full answers.
    while (free_top != NIL_SLOT) run_row(mk_row(rand_req(FUNC_PUSH), 1'b0, ST_INSERTED, 4'd0));
    run_row(mk_row(rand_req(FUNC_PUSH), 1'b1, ST_FULL, 4'd0));
    r = rand_req(FUNC_INSERT);
    r.key = slot_rec[list_top].key;
    run_row(mk_row(r, 1'b1, ST_FULL, 4'd0));
    run_row(mk_row(rand_req(FUNC_WALK), 1'b0, ST_INSERTED, 4'd0));
    in_if.valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side: random stalls, and one long hold-off that backs up the block.
  initial begin : result_taker
    int unsigned stall;
    bit          held;
    out_if.ready <= 1'b0;
    stall = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && taken_cnt >= 200) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        stall = idle_gap();
      end
    end
  end

  // Compare each result item with the oldest booked one.
  always @(posedge clk) begin : result_check
    resp_t got;
    resp_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.status   = out_if.status;
      got.slot     = out_if.slot;
      got.key      = out_if.out_key;
      got.given    = out_if.out_given;
      got.mid_init = out_if.out_initial;
      got.years    = out_if.out_years;
      got.category = out_if.out_category;
      got.last     = out_if.last;
      taken_cnt++;
      if (due_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result: %s", resp_text(got));
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("mismatch: want %s", resp_text(want));
            $display("          got  %s", resp_text(got));
          end
        end
      end
    end
  end

  // Ends the run when no item moves on either side for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial taken_cnt = 0;
  initial idle_cyc = 0;

endmodule
